[rtl/core/coep_pkg.sv]
// coep_pkg: shared constants and the CORDIC arctangent table for the
// circular orbit Earth-fixed position block. No dependencies.
`default_nettype none
package coep_pkg;

	localparam logic [2:0] REG_RADIUS     = 3'd0;
	localparam logic [2:0] REG_ORBIT_RATE = 3'd1;
	localparam logic [2:0] REG_INIT_ANOM  = 3'd2;
	localparam logic [2:0] REG_COS_NODE   = 3'd3;
	localparam logic [2:0] REG_SIN_NODE   = 3'd4;
	localparam logic [2:0] REG_COS_INCL   = 3'd5;
	localparam logic [2:0] REG_SIN_INCL   = 3'd6;
	localparam logic [2:0] REG_EARTH_RATE = 3'd7;

	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [27:0] POS_LIMIT   = 28'sd134217727;

	// clamp a raw 32-bit register value to [-1.0, 1.0] in Q1.30
	function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30) r = ONE_Q30;
		else if (v < -ONE_Q30) r = -ONE_Q30;
		else r = v;
		return r;
	endfunction

	// arctangent of 2^-k in 2^32 per turn, aligned to ab bits per turn (round half up)
	function automatic logic [39:0] atan_angle(input int k, input int ab);
		logic [31:0] t;
		logic [71:0] w;
		case (k)
			0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
			3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
			6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
			9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
			12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
			15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
			18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
			21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
			24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
			27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
			30: t = 32'd1;
			default: t = 32'd0;
		endcase
		if (ab >= 32) w = 72'(t) << (ab - 32);
		else w = (72'(t) + (72'd1 << (31 - ab))) >> (32 - ab);
		return w[39:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/coep_cordic.sv]
// coep_cordic: pipelined rotation-mode CORDIC, one stage per iteration,
// giving clamped Q1.30 cosine and sine of a binary angle. Uses coep_pkg.
`default_nettype none
module coep_cordic #(
	parameter int STAGES     = 30,
	parameter int ANGLE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output logic                       out_valid,
	output logic signed [31:0]         cos_out,
	output logic signed [31:0]         sin_out
);
	localparam int XW = 34;
	localparam int ZW = ANGLE_BITS + 1;

	logic [STAGES:0]        vld_s;
	logic signed [XW-1:0]   x_s [0:STAGES];
	logic signed [XW-1:0]   y_s [0:STAGES];
	logic signed [ZW-1:0]   z_s [0:STAGES];
	logic [1:0]             q_s [0:STAGES];

	// entry: quadrant from the top two bits, residue rotated from (gain, 0)
	assign vld_s[0] = in_valid;
	assign x_s[0]   = coep_pkg::CORDIC_GAIN;
	assign y_s[0]   = '0;
	assign z_s[0]   = ZW'(angle[ANGLE_BITS-3:0]);
	assign q_s[0]   = angle[ANGLE_BITS-1 -: 2];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [39:0] ATAN = coep_pkg::atan_angle(i, ANGLE_BITS);
		localparam logic signed [ZW-1:0] A_I = ZW'(ATAN);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			q_s[i+1] <= q_s[i];
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - A_I;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + A_I;
			end
		end
	end

	logic signed [31:0] xc, yc;

	always_comb begin
		if (x_s[STAGES] > XW'(coep_pkg::ONE_Q30)) xc = coep_pkg::ONE_Q30;
		else if (x_s[STAGES] < -XW'(coep_pkg::ONE_Q30)) xc = -coep_pkg::ONE_Q30;
		else xc = 32'(x_s[STAGES]);
		if (y_s[STAGES] > XW'(coep_pkg::ONE_Q30)) yc = coep_pkg::ONE_Q30;
		else if (y_s[STAGES] < -XW'(coep_pkg::ONE_Q30)) yc = -coep_pkg::ONE_Q30;
		else yc = 32'(y_s[STAGES]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= vld_s[STAGES];
	end

	always_ff @(posedge clk) begin
		case (q_s[STAGES])
			2'd0: begin cos_out <= xc;  sin_out <= yc;  end
			2'd1: begin cos_out <= -yc; sin_out <= xc;  end
			2'd2: begin cos_out <= -xc; sin_out <= -yc; end
			default: begin cos_out <= yc; sin_out <= -xc; end
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/circular_orbit_ecef_position.sv]
// circular_orbit_ecef_position: top level, Earth-fixed satellite position
// from simulation time. Uses coep_pkg and coep_cordic.
`default_nettype none
// Usage:
//  - Configuration: write cfg_data to register cfg_index while cfg_we is high
//    (0 radius, 1 orbit_rate, 2 initial_anomaly, 3..6 node/inclination trig in
//    Q1.30, 7 earth_rate). Only write while no query is in flight. Trig values
//    beyond +-1.0 are clamped at write time.
//  - Input: a transfer happens on a clock edge with start high and busy low.
//    busy is always low: the pipeline takes a new sim_time every cycle.
//  - Output: done pulses for one cycle with pos_x/pos_y/pos_z valid. The
//    receiver cannot stall, and none is needed since nothing is held back.
//  - Pipeline: one result per cycle sustained. Depth is set by the CORDIC,
//    one iteration per stage; 2 stages form the angles from split
//    rate*time products, 1 clamps and maps quadrants, 4 do the rotation
//    products.
//  - Reset: arst_n clears all valid bits and loads the register defaults;
//    queries in flight are dropped.
module circular_orbit_ecef_position #(
	parameter int CORDIC_STAGES = 30,
	parameter int ANGLE_BITS    = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [47:0]        sim_time,
	output logic                    done,
	output logic signed [27:0]      pos_x,
	output logic signed [27:0]      pos_y,
	output logic signed [27:0]      pos_z,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [39:0]        cfg_data
);
	// configuration registers
	logic [26:0]        radius_q;
	logic [39:0]        orbit_rate_q, earth_rate_q;
	logic [31:0]        init_anom_q;
	logic signed [31:0] cos_node_q, sin_node_q, cos_incl_q, sin_incl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= 27'd6771000;
			orbit_rate_q <= '0;
			init_anom_q  <= '0;
			cos_node_q   <= coep_pkg::ONE_Q30;
			sin_node_q   <= '0;
			cos_incl_q   <= coep_pkg::ONE_Q30;
			sin_incl_q   <= '0;
			earth_rate_q <= 40'd3261218913;
		end else if (cfg_we) begin
			unique case (cfg_index)
				coep_pkg::REG_RADIUS:     radius_q     <= cfg_data[26:0];
				coep_pkg::REG_ORBIT_RATE: orbit_rate_q <= cfg_data;
				coep_pkg::REG_INIT_ANOM:  init_anom_q  <= cfg_data[31:0];
				coep_pkg::REG_COS_NODE:   cos_node_q   <= coep_pkg::clamp_q30(cfg_data[31:0]);
				coep_pkg::REG_SIN_NODE:   sin_node_q   <= coep_pkg::clamp_q30(cfg_data[31:0]);
				coep_pkg::REG_COS_INCL:   cos_incl_q   <= coep_pkg::clamp_q30(cfg_data[31:0]);
				coep_pkg::REG_SIN_INCL:   sin_incl_q   <= coep_pkg::clamp_q30(cfg_data[31:0]);
				coep_pkg::REG_EARTH_RATE: earth_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	logic accept;
	assign accept = start && !busy;

	// stage 1: rate * time as three 40x16 partial products per angle
	logic        vld_s1;
	logic [55:0] ao0_s1, ao1_s1, ao2_s1, ae0_s1, ae1_s1, ae2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		ao0_s1 <= orbit_rate_q * sim_time[15:0];
		ao1_s1 <= orbit_rate_q * sim_time[31:16];
		ao2_s1 <= orbit_rate_q * sim_time[47:32];
		ae0_s1 <= earth_rate_q * sim_time[15:0];
		ae1_s1 <= earth_rate_q * sim_time[31:16];
		ae2_s1 <= earth_rate_q * sim_time[47:32];
	end

	// stage 2: sum modulo 2^64, take the top angle bits, add initial anomaly
	logic                  vld_s2;
	logic [ANGLE_BITS-1:0] anom_s2, earth_s2;
	logic [63:0]           sum_o, sum_e;
	logic [ANGLE_BITS-1:0] ia_al;

	always_comb begin
		sum_o = 64'(ao0_s1) + (64'(ao1_s1) << 16) + (64'(ao2_s1) << 32);
		sum_e = 64'(ae0_s1) + (64'(ae1_s1) << 16) + (64'(ae2_s1) << 32);
		ia_al = ANGLE_BITS'({init_anom_q, {ANGLE_BITS{1'b0}}} >> 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		anom_s2  <= sum_o[63 -: ANGLE_BITS] + ia_al;
		earth_s2 <= sum_e[63 -: ANGLE_BITS];
	end

	// CORDIC pair, equal latency
	logic               va, ve;
	logic signed [31:0] cv, sv, ct, st;

	coep_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_cordic_anom (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s2), .angle(anom_s2),
		.out_valid(va), .cos_out(cv), .sin_out(sv)
	);

	coep_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_cordic_earth (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s2), .angle(earth_s2),
		.out_valid(ve), .cos_out(ct), .sin_out(st)
	);

	// stage P1: sinV * cos_incl and sinV * sin_incl
	logic               vld_p1;
	logic signed [31:0] svci_p1, svsi_p1, cv_p1, ct_p1, st_p1;
	logic signed [63:0] m_ci, m_si;

	always_comb begin
		m_ci = sv * cos_incl_q;
		m_si = sv * sin_incl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p1 <= 1'b0;
		else vld_p1 <= va && ve;
	end

	always_ff @(posedge clk) begin
		svci_p1 <= 32'((m_ci + (64'sd1 <<< 29)) >>> 30);
		svsi_p1 <= 32'((m_si + (64'sd1 <<< 29)) >>> 30);
		cv_p1   <= cv;
		ct_p1   <= ct;
		st_p1   <= st;
	end

	// stage P2: inertial unit vector in the orbit-node frame
	logic               vld_p2;
	logic signed [33:0] ux_p2, uy_p2;
	logic signed [31:0] svsi_p2, ct_p2, st_p2;
	logic signed [63:0] m_cc, m_ss, m_sc, m_cs;
	logic signed [65:0] sx, sy;

	always_comb begin
		m_cc = cos_node_q * cv_p1;
		m_ss = sin_node_q * svci_p1;
		m_sc = sin_node_q * cv_p1;
		m_cs = cos_node_q * svci_p1;
		sx = 66'(m_cc) - 66'(m_ss) + (66'sd1 <<< 29);
		sy = 66'(m_sc) + 66'(m_cs) + (66'sd1 <<< 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p2 <= 1'b0;
		else vld_p2 <= vld_p1;
	end

	always_ff @(posedge clk) begin
		ux_p2   <= 34'(sx >>> 30);
		uy_p2   <= 34'(sy >>> 30);
		svsi_p2 <= svsi_p1;
		ct_p2   <= ct_p1;
		st_p2   <= st_p1;
	end

	// stage P3: scale by radius; x,y to Q.4 meters, z to whole meters
	logic               vld_p3;
	logic signed [35:0] ex_p3, ey_p3;
	logic signed [30:0] pz_p3;
	logic signed [31:0] ct_p3, st_p3;
	logic signed [27:0] rad;
	logic signed [61:0] m_rx, m_ry;
	logic signed [59:0] m_rz;

	always_comb begin
		rad  = {1'b0, radius_q};
		m_rx = rad * ux_p2;
		m_ry = rad * uy_p2;
		m_rz = rad * svsi_p2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p3 <= 1'b0;
		else vld_p3 <= vld_p2;
	end

	always_ff @(posedge clk) begin
		ex_p3 <= 36'((m_rx + (62'sd1 <<< 25)) >>> 26);
		ey_p3 <= 36'((m_ry + (62'sd1 <<< 25)) >>> 26);
		pz_p3 <= 31'((61'(m_rz) + (61'sd1 <<< 29)) >>> 30);
		ct_p3 <= ct_p2;
		st_p3 <= st_p2;
	end

	// stage P4: Earth rotation, rounding to meters and saturation
	logic signed [67:0] m_xc, m_ys, m_yc, m_xs;
	logic signed [68:0] fx, fy;
	logic signed [34:0] px, py;
	logic signed [27:0] px_sat, py_sat, pz_sat;

	always_comb begin
		m_xc = ex_p3 * ct_p3;
		m_ys = ey_p3 * st_p3;
		m_yc = ey_p3 * ct_p3;
		m_xs = ex_p3 * st_p3;
		fx = 69'(m_xc) + 69'(m_ys) + (69'sd1 <<< 33);
		fy = 69'(m_yc) - 69'(m_xs) + (69'sd1 <<< 33);
		px = 35'(fx >>> 34);
		py = 35'(fy >>> 34);
		if (px > 35'(coep_pkg::POS_LIMIT)) px_sat = coep_pkg::POS_LIMIT;
		else if (px < -35'(coep_pkg::POS_LIMIT)) px_sat = -coep_pkg::POS_LIMIT;
		else px_sat = 28'(px);
		if (py > 35'(coep_pkg::POS_LIMIT)) py_sat = coep_pkg::POS_LIMIT;
		else if (py < -35'(coep_pkg::POS_LIMIT)) py_sat = -coep_pkg::POS_LIMIT;
		else py_sat = 28'(py);
		if (pz_p3 > 31'(coep_pkg::POS_LIMIT)) pz_sat = coep_pkg::POS_LIMIT;
		else if (pz_p3 < -31'(coep_pkg::POS_LIMIT)) pz_sat = -coep_pkg::POS_LIMIT;
		else pz_sat = 28'(pz_p3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_p3;
	end

	always_ff @(posedge clk) begin
		pos_x <= px_sat;
		pos_y <= py_sat;
		pos_z <= pz_sat;
	end
endmodule
`default_nettype wire

[rtl/core/coep_checker.sv]
// coep_checker: port-level assertions for circular_orbit_ecef_position,
// attached by bind. No package dependency.
`default_nettype none
module coep_checker #(
	parameter int LATENCY = 37
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [27:0] pos_x,
	input wire logic signed [27:0] pos_y,
	input wire logic signed [27:0] pos_z
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer produced no result");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transfer");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pos_x != -28'sd134217728 && pos_y != -28'sd134217728 &&
			pos_z != -28'sd134217728))
		else $error("position out of range");
endmodule

bind circular_orbit_ecef_position coep_checker #(.LATENCY(CORDIC_STAGES + 7)) u_coep_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
);
`default_nettype wire

[test/tb_circular_orbit_ecef_position.sv]
// tb_circular_orbit_ecef_position: self-checking bench for the orbit position block.
// Depends on coep_pkg and circular_orbit_ecef_position (rtl/core).
`default_nettype none
module tb_circular_orbit_ecef_position;

	localparam int STAGES  = 30;
	localparam int ABITS   = 32;
	localparam int LATENCY = STAGES + 7;

	typedef struct packed {
		logic signed [27:0] x;
		logic signed [27:0] y;
		logic signed [27:0] z;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [47:0] sim_time = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [39:0] cfg_data = '0;
	wire busy, done;
	wire signed [27:0] pos_x, pos_y, pos_z;

	// predictor copy of the register file
	logic [26:0] m_radius;
	logic [39:0] m_orbit_rate, m_earth_rate;
	logic [31:0] m_init_anom, m_cos_node, m_sin_node, m_cos_incl, m_sin_incl;

	position_t expected_positions[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	bit gaps_on = 1'b1;

	circular_orbit_ecef_position #(.CORDIC_STAGES(STAGES), .ANGLE_BITS(ABITS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sim_time(sim_time),
		.done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// round-half-up shift on 128-bit signed values
	function automatic logic signed [127:0] rnd(input logic signed [127:0] v, input int s);
		return (v + (128'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [63:0] trig_val(input logic [31:0] r);
		logic signed [63:0] v;
		v = 64'(signed'(r));
		if (v > 64'sd1073741824) v = 64'sd1073741824;
		else if (v < -64'sd1073741824) v = -64'sd1073741824;
		return v;
	endfunction

	function automatic logic signed [63:0] lim(input logic signed [63:0] v,
			input logic signed [63:0] l);
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

	function automatic logic [31:0] atan_ref(input int k);
		logic [31:0] t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return t[k];
	endfunction

	// rotation CORDIC from the gain-scaled unit vector, quadrant from the top bits
	task automatic sincos(input logic [31:0] ang, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic signed [63:0] x, y, z, nx;
		logic [1:0] q;
		q = ang[31:30];
		z = 64'(ang[29:0]);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z = z - 64'(atan_ref(i));
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z = z + 64'(atan_ref(i));
			end
			x = nx;
		end
		x = lim(x, 64'sd1073741824);
		y = lim(y, 64'sd1073741824);
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_position(input logic [47:0] t, output position_t p);
		logic [127:0] prod;
		logic [31:0] anom, earth;
		logic signed [63:0] cv, sv, ct, st, co, so, ci, si;
		logic signed [127:0] r, svci, ux, uy, ex, ey;
		prod = 128'(m_orbit_rate) * 128'(t);
		anom = prod[63:32] + m_init_anom;
		prod = 128'(m_earth_rate) * 128'(t);
		earth = prod[63:32];
		sincos(anom, cv, sv);
		sincos(earth, ct, st);
		co = trig_val(m_cos_node); so = trig_val(m_sin_node);
		ci = trig_val(m_cos_incl); si = trig_val(m_sin_incl);
		r = 128'(m_radius);
		svci = rnd(128'(sv) * 128'(ci), 30);
		ux = rnd(128'(co) * 128'(cv) - 128'(so) * svci, 30);
		uy = rnd(128'(so) * 128'(cv) + 128'(co) * svci, 30);
		ex = rnd(r * ux, 26);
		ey = rnd(r * uy, 26);
		p.x = 28'(lim(64'(rnd(ex * 128'(ct) + ey * 128'(st), 34)), 64'sd134217727));
		p.y = 28'(lim(64'(rnd(ey * 128'(ct) - ex * 128'(st), 34)), 64'sd134217727));
		p.z = 28'(lim(64'(rnd(r * rnd(128'(sv) * 128'(si), 30), 30)), 64'sd134217727));
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		position_t e;
		if (arst_n && done) begin
			if (expected_positions.size() == 0) begin
				$error("result with no transfer outstanding");
				errors++;
			end else begin
				e = expected_positions.pop_front();
				checked++;
				if (pos_x !== e.x) begin $error("pos_x exp %0d got %0d", e.x, pos_x); errors++; end
				if (pos_y !== e.y) begin $error("pos_y exp %0d got %0d", e.y, pos_y); errors++; end
				if (pos_z !== e.z) begin $error("pos_z exp %0d got %0d", e.z, pos_z); errors++; end
			end
		end
	end

	// one query transfer; start stays high across back-to-back calls
	task automatic send_time(input logic [47:0] t);
		position_t p;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		sim_time <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_position(t, p);
		expected_positions.push_back(p);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_positions.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// register write while idle; out-of-list indices do not exist (3-bit index)
	task automatic write_reg(input logic [2:0] idx, input logic [39:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			coep_pkg::REG_RADIUS:     m_radius = v[26:0];
			coep_pkg::REG_ORBIT_RATE: m_orbit_rate = v;
			coep_pkg::REG_INIT_ANOM:  m_init_anom = v[31:0];
			coep_pkg::REG_COS_NODE:   m_cos_node = v[31:0];
			coep_pkg::REG_SIN_NODE:   m_sin_node = v[31:0];
			coep_pkg::REG_COS_INCL:   m_cos_incl = v[31:0];
			coep_pkg::REG_SIN_INCL:   m_sin_incl = v[31:0];
			coep_pkg::REG_EARTH_RATE: m_earth_rate = v;
			default: ;
		endcase
	endtask

	function automatic logic [47:0] rand_time();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] rand_trig();
		case ($urandom_range(0, 3))
			0: return 32'(coep_pkg::ONE_Q30);
			1: return 32'(-coep_pkg::ONE_Q30);
			2: return $urandom; // often beyond +-1.0, exercises clamping
			default: return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) >>> 1);
		endcase
	endfunction

	task automatic randomize_regs(input bit extreme);
		write_reg(coep_pkg::REG_RADIUS,
			extreme ? 40'h7FF_FFFF : 40'($urandom_range(0, 134217727)));
		write_reg(coep_pkg::REG_ORBIT_RATE,
			extreme ? 40'hFF_FFFF_FFFF : 40'({$urandom, $urandom}));
		write_reg(coep_pkg::REG_INIT_ANOM, 40'($urandom));
		write_reg(coep_pkg::REG_COS_NODE, 40'(rand_trig()));
		write_reg(coep_pkg::REG_SIN_NODE, 40'(rand_trig()));
		write_reg(coep_pkg::REG_COS_INCL, 40'(rand_trig()));
		write_reg(coep_pkg::REG_SIN_INCL, 40'(rand_trig()));
		write_reg(coep_pkg::REG_EARTH_RATE,
			extreme ? 40'hFF_FFFF_FFFF : 40'({$urandom, $urandom}));
	endtask

	// reset defaults, field extremes
	task automatic test_defaults;
		send_time('0);
		send_time('1);
		send_time(48'd1);
		send_time(48'h0000_5A00_0000);
		send_time(48'h8000_0000_0000);
		drain();
	endtask

	// full-scale radius with unit trig terms drives coordinates into saturation
	task automatic test_saturation;
		write_reg(coep_pkg::REG_RADIUS, 40'h7FF_FFFF);
		write_reg(coep_pkg::REG_COS_NODE, 40'(32'h7FFF_FFFF));
		write_reg(coep_pkg::REG_SIN_NODE, 40'(32'h7FFF_FFFF));
		write_reg(coep_pkg::REG_COS_INCL, 40'(32'h8000_0000));
		write_reg(coep_pkg::REG_SIN_INCL, 40'(32'h8000_0000));
		write_reg(coep_pkg::REG_ORBIT_RATE, 40'hFF_FFFF_FFFF);
		write_reg(coep_pkg::REG_INIT_ANOM, 40'(32'h4000_0000));
		write_reg(coep_pkg::REG_EARTH_RATE, 40'd0);
		for (int i = 0; i < 8; i++) send_time(48'(i) << (6 * i));
		drain();
		write_reg(coep_pkg::REG_RADIUS, 40'd0);
		send_time('1);
		drain();
		write_reg(coep_pkg::REG_EARTH_RATE, 40'hFF_FFFF_FFFF);
		write_reg(coep_pkg::REG_RADIUS, 40'd6771000);
		for (int i = 0; i < 6; i++) send_time(rand_time());
		drain();
	endtask

	task automatic test_random(input int phases, input int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			randomize_regs(ph % 5 == 0);
			for (int i = 0; i < per_phase; i++)
				send_time(($urandom_range(0, 3) == 0) ? rand_time() : 48'($urandom));
			drain();
		end
	endtask

	initial begin
		m_radius = 27'd6771000; m_orbit_rate = '0; m_init_anom = '0;
		m_cos_node = 32'(coep_pkg::ONE_Q30); m_sin_node = '0;
		m_cos_incl = 32'(coep_pkg::ONE_Q30); m_sin_incl = '0;
		m_earth_rate = 40'd3261218913;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults();
		test_saturation();
		test_random(10, 100);
		gaps_on = 1'b0; // closing stretch runs back to back
		test_random(2, 100);
		$display("covered %0d queries, %0d results checked, over 12 random register sets",
			sent, checked);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

[circular_orbit_ecef_position.f]
rtl/core/coep_pkg.sv
rtl/core/coep_cordic.sv
rtl/core/circular_orbit_ecef_position.sv
rtl/core/coep_checker.sv
test/tb_circular_orbit_ecef_position.sv
